// File: hdl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions for the streaming SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef logic [31:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_START,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic put_byte;
		logic start_pad;
		logic put_pad;
		logic load_vars;
		logic do_round;
		logic add_chain;
		logic reset_chain;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic [5:0] byte_pos;
		logic [5:0] pad_pos;
		logic       len_blk;
		logic       round_last;
	} sts_t;

	localparam word_t H_INIT [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam word_t K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LEN_POS    = 6'd56;
	localparam logic [5:0] LAST_POS   = 6'd63;
	localparam logic [5:0] LAST_ROUND = 6'd63;

	function automatic word_t rotr(input word_t x, input int unsigned n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// File: hdl/sha_if.sv
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels carrying message bytes in and digest words out.
// ----------------------------------------------------------------------------
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: hdl/sha_datapath.sv
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, message schedule, round unit, chaining value and byte count.
// ----------------------------------------------------------------------------
module sha_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sha_pkg::cmd_t        cmd,
	input  logic [7:0]           data_byte,
	input  logic [2:0]           rd_idx,
	output sha_pkg::sts_t        sts,
	output sha_pkg::word_t       digest
);

	sha_pkg::word_t w_q [16];
	sha_pkg::word_t v_q [8];
	sha_pkg::word_t h_q [8];
	logic [60:0]    bytes_q;
	logic [5:0]     rnd_q;
	logic [5:0]     pad_pos_q;
	logic [63:0]    bits_q;
	logic           pad_first_q;
	logic           len_blk_q;

	logic [7:0]     pad_val;
	logic [5:0]     wpos;
	logic [7:0]     wbyte;
	logic [3:0]     wi;
	logic [4:0]     sh;
	sha_pkg::word_t x2, x15, s0, s1, wn, wr, t1, t2, e, a;

	assign sts.byte_pos   = bytes_q[5:0];
	assign sts.pad_pos    = pad_pos_q;
	assign sts.len_blk    = len_blk_q;
	assign sts.round_last = (rnd_q == sha_pkg::LAST_ROUND);
	assign digest = h_q[rd_idx];

	// pad stream: 0x80 at message end, zeros, then big-endian bit length
	always_comb begin
		priority if (pad_first_q)
			pad_val = sha_pkg::PAD_BYTE;
		else if (len_blk_q && pad_pos_q >= sha_pkg::LEN_POS)
			pad_val = 8'(bits_q >> {~pad_pos_q[2:0], 3'b0});
		else
			pad_val = '0;
	end

	assign wpos  = cmd.put_byte ? bytes_q[5:0] : pad_pos_q;
	assign wbyte = cmd.put_byte ? data_byte : pad_val;
	assign wi    = wpos[5:2];
	assign sh    = {~wpos[1:0], 3'b0};

	assign x2  = w_q[4'(rnd_q - 6'd2)];
	assign x15 = w_q[4'(rnd_q - 6'd15)];
	assign s1  = sha_pkg::rotr(x2, 17) ^ sha_pkg::rotr(x2, 19) ^ (x2 >> 10);
	assign s0  = sha_pkg::rotr(x15, 7) ^ sha_pkg::rotr(x15, 18) ^ (x15 >> 3);
	assign wn  = s1 + w_q[4'(rnd_q - 6'd7)] + s0 + w_q[rnd_q[3:0]];
	assign wr  = (rnd_q[5:4] != 2'd0) ? wn : w_q[rnd_q[3:0]];
	assign e   = v_q[4];
	assign a   = v_q[0];
	assign t1  = v_q[7] + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
		+ ((e & v_q[5]) ^ (~e & v_q[6])) + sha_pkg::K_TAB[rnd_q] + wr;
	assign t2  = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
		+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk) begin
		if (cmd.put_byte || cmd.put_pad) begin
			if (wpos[1:0] == 2'd0)
				w_q[wi] <= 32'(wbyte) << sh;
			else
				w_q[wi] <= w_q[wi] | (32'(wbyte) << sh);
		end else if (cmd.do_round) begin
			w_q[rnd_q[3:0]] <= wr;
		end
		if (cmd.load_vars) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= h_q[i];
		end else if (cmd.do_round) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				h_q[i] <= sha_pkg::H_INIT[i];
			bytes_q     <= '0;
			rnd_q       <= '0;
			pad_pos_q   <= '0;
			bits_q      <= '0;
			pad_first_q <= 1'b0;
			len_blk_q   <= 1'b0;
		end else begin
			if (cmd.load_vars)
				rnd_q <= '0;
			else if (cmd.do_round)
				rnd_q <= rnd_q + 6'd1;
			if (cmd.reset_chain) begin
				for (int i = 0; i < 8; i++)
					h_q[i] <= sha_pkg::H_INIT[i];
				bytes_q <= '0;
			end else begin
				if (cmd.add_chain) begin
					for (int i = 0; i < 8; i++)
						h_q[i] <= h_q[i] + v_q[i];
				end
				if (cmd.put_byte)
					bytes_q <= bytes_q + 61'd1;
			end
			// start of padding: latch length and position
			if (cmd.start_pad) begin
				pad_pos_q   <= bytes_q[5:0];
				bits_q      <= {bytes_q, 3'b0};
				pad_first_q <= 1'b1;
				len_blk_q   <= (bytes_q[5:0] < sha_pkg::LEN_POS);
			end else if (cmd.put_pad) begin
				pad_pos_q   <= pad_pos_q + 6'd1;
				pad_first_q <= 1'b0;
				if (pad_pos_q == sha_pkg::LAST_POS)
					len_blk_q <= 1'b1;
			end
		end
	end

endmodule

// File: hdl/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer for byte intake, 64-round compression, padding and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           byte_present,
	input  logic           end_of_message,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [2:0]     word_index,
	output logic           last_word,
	output sha_pkg::cmd_t  cmd,
	input  sha_pkg::sts_t  sts
);

	sha_pkg::state_t state_q, state_d;
	logic            padblk_q, padblk_d;  // block in compression is a padding block
	logic            lenblk_q, lenblk_d;  // block in compression holds the length
	logic            end_q, end_d;        // end pending after this block
	logic [2:0]      idx_q, idx_d;

	assign word_index = idx_q;
	assign last_word  = (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sha_pkg::ST_IDLE;
			padblk_q <= 1'b0;
			lenblk_q <= 1'b0;
			end_q    <= 1'b0;
			idx_q    <= '0;
		end else begin
			state_q  <= state_d;
			padblk_q <= padblk_d;
			lenblk_q <= lenblk_d;
			end_q    <= end_d;
			idx_q    <= idx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		padblk_d  = padblk_q;
		lenblk_d  = lenblk_q;
		end_d     = end_q;
		idx_d     = idx_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			sha_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.put_byte = byte_present;
					end_d = end_of_message;
					priority if (byte_present && sts.byte_pos == sha_pkg::LAST_POS) begin
						cmd.load_vars = 1'b1;
						padblk_d = 1'b0;
						lenblk_d = 1'b0;
						state_d  = sha_pkg::ST_ROUND;
					end else if (end_of_message) begin
						state_d = sha_pkg::ST_PAD_START;
					end
				end
			end
			sha_pkg::ST_PAD_START: begin
				cmd.start_pad = 1'b1;
				state_d = sha_pkg::ST_PAD;
			end
			sha_pkg::ST_PAD: begin
				cmd.put_pad = 1'b1;
				if (sts.pad_pos == sha_pkg::LAST_POS) begin
					cmd.load_vars = 1'b1;
					padblk_d = 1'b1;
					lenblk_d = sts.len_blk;
					state_d  = sha_pkg::ST_ROUND;
				end
			end
			sha_pkg::ST_ROUND: begin
				cmd.do_round = 1'b1;
				if (sts.round_last)
					state_d = sha_pkg::ST_ADD;
			end
			sha_pkg::ST_ADD: begin
				cmd.add_chain = 1'b1;
				if (!padblk_q) begin
					state_d = end_q ? sha_pkg::ST_PAD_START : sha_pkg::ST_IDLE;
				end else if (lenblk_q) begin
					state_d = sha_pkg::ST_EMIT;
					idx_d   = '0;
				end else begin
					state_d = sha_pkg::ST_PAD;
				end
			end
			sha_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					idx_d = idx_q + 3'd1;
					if (idx_q == 3'd7) begin
						cmd.reset_chain = 1'b1;
						end_d   = 1'b0;
						state_d = sha_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = sha_pkg::ST_IDLE;
		endcase
	end

endmodule

// File: hdl/sha256_stream_hash_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hash_top
// Streaming SHA-256: bytes in, eight digest words out per message.
//
//   channel   dir   payload
//   in        sink  data_byte, byte_present, end_of_message
//   out       src   digest_word, word_index, last_word
//
// a byte that does not fill a block is taken while in.ready stays high; a block-filling
// byte holds in.ready low through 64 rounds on one round unit and one chain add
// an end item adds a state to latch the length, one pad byte per cycle up to the
// block end and the rounds and chain add of each padding block (one or two)
// then eight output words, each stalled while out.ready is low
// reset loads the initial hash values and clears the byte count
// ----------------------------------------------------------------------------
module sha256_stream_hash_top (
	input  logic         clk,
	input  logic         arst_n,
	sha_in_if.sink       in,
	sha_out_if.source    out
);

	sha_pkg::cmd_t cmd;
	sha_pkg::sts_t sts;

	sha_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in.valid),
		.in_ready       (in.ready),
		.byte_present   (in.byte_present),
		.end_of_message (in.end_of_message),
		.out_valid      (out.valid),
		.out_ready      (out.ready),
		.word_index     (out.word_index),
		.last_word      (out.last_word),
		.cmd            (cmd),
		.sts            (sts)
	);

	sha_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (in.data_byte),
		.rd_idx    (out.word_index),
		.sts       (sts),
		.digest    (out.digest_word)
	);

endmodule
